// ===== rtl/quad_bicubic_interpolator_defines.svh =====
// Assertion macros of the quad bicubic interpolator RTL.
`ifndef QUAD_BICUBIC_INTERPOLATOR_DEFINES_SVH
`define QUAD_BICUBIC_INTERPOLATOR_DEFINES_SVH
`ifndef SYNTH
`define QBI_ASSERT(lbl, clk, rst_n, prop, msg) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define QBI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define QBI_ASSERT(lbl, clk, rst_n, prop, msg)
`define QBI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/qbi_pkg.sv =====
// Shared constants and types of the quad bicubic interpolator.
`timescale 1ns / 1ps
package qbi_pkg;
    localparam int COORD_WIDTH_DEF     = 12;
    localparam int VALUE_FRAC_BITS_DEF = 14;
    localparam int GUARD_BITS          = 8;
    localparam int VALUE_WIDTH         = 16;
    localparam int CFG_ADDR_W          = 3;
    localparam int CFG_DATA_W          = 16;
    localparam int VAL_MAX             = 32767;
    localparam int VAL_MIN             = -32768;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_LEFT_X,
        REG_TOP_Y,
        REG_RIGHT_X,
        REG_BOTTOM_Y,
        REG_VAL_TL,
        REG_VAL_TR,
        REG_VAL_BR,
        REG_VAL_BL
    } cfg_reg_t;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] tl;
        logic signed [VALUE_WIDTH-1:0] tr;
        logic signed [VALUE_WIDTH-1:0] br;
        logic signed [VALUE_WIDTH-1:0] bl;
    } corners_t;
endpackage

// ===== rtl/quad_bicubic_interpolator.sv =====
// Depth grows with FRAC_BITS, not COORD_WIDTH; divider and blend pipeline advance together.
// Throughput: one transaction per cycle while out_ready does not stall the output.
// A two-entry queue separates the input side from the back end.
// Reset is asynchronous and active low; it empties the pipeline and sets the registers
// to a one-by-one quad at the origin with zero corner values.
`timescale 1ns / 1ps
module quad_bicubic_interpolator #(
    parameter int COORD_WIDTH     = qbi_pkg::COORD_WIDTH_DEF,
    parameter int VALUE_FRAC_BITS = qbi_pkg::VALUE_FRAC_BITS_DEF,
    localparam int IN_W = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [IN_W-1:0]                   s_axis_tdata,  // pixel_x, pixel_y
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [qbi_pkg::VALUE_WIDTH-1:0]   m_axis_tdata,  // interp_value
    output logic [1:0]                        m_axis_tuser,  // saturated, divide_error
    input  logic                              cfg_we,
    input  logic [qbi_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [qbi_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    localparam int NW   = COORD_WIDTH + VALUE_FRAC_BITS + 2;
    localparam int DW   = COORD_WIDTH + 1;
    localparam int ENTW = 2 * (NW + DW + 1) + 1;

    logic [COORD_WIDTH-1:0] left_x_reg, top_y_reg, right_x_reg, bottom_y_reg;
    qbi_pkg::corners_t      corners_reg;
    logic                   q_valid, q_pop;
    logic [ENTW-1:0]        q_data;
    logic signed [qbi_pkg::VALUE_WIDTH-1:0] value;
    logic                   sat, err;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_x_reg   <= '0;
            top_y_reg    <= '0;
            right_x_reg  <= COORD_WIDTH'(1);
            bottom_y_reg <= COORD_WIDTH'(1);
            corners_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                qbi_pkg::REG_LEFT_X:   left_x_reg     <= cfg_wdata[COORD_WIDTH-1:0];
                qbi_pkg::REG_TOP_Y:    top_y_reg      <= cfg_wdata[COORD_WIDTH-1:0];
                qbi_pkg::REG_RIGHT_X:  right_x_reg    <= cfg_wdata[COORD_WIDTH-1:0];
                qbi_pkg::REG_BOTTOM_Y: bottom_y_reg   <= cfg_wdata[COORD_WIDTH-1:0];
                qbi_pkg::REG_VAL_TL:   corners_reg.tl <= cfg_wdata;
                qbi_pkg::REG_VAL_TR:   corners_reg.tr <= cfg_wdata;
                qbi_pkg::REG_VAL_BR:   corners_reg.br <= cfg_wdata;
                qbi_pkg::REG_VAL_BL:   corners_reg.bl <= cfg_wdata;
                default:               ;
            endcase
        end
    end

    qbi_front #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(VALUE_FRAC_BITS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .pixel_x  (s_axis_tdata[COORD_WIDTH-1:0]),
        .pixel_y  (s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
        .left_x   (left_x_reg),
        .top_y    (top_y_reg),
        .right_x  (right_x_reg),
        .bottom_y (bottom_y_reg),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop)
    );

    qbi_back #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(VALUE_FRAC_BITS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .q_pop        (q_pop),
        .corners      (corners_reg),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .interp_value (value),
        .saturated    (sat),
        .divide_error (err)
    );

    assign m_axis_tdata = value;
    assign m_axis_tuser = {err, sat};
endmodule

// ===== rtl/qbi_div.sv =====
// Pipelined restoring divider giving the clamped, rounded normalised coordinate.
`timescale 1ns / 1ps
module qbi_div #(
    parameter int COORD_WIDTH = qbi_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = qbi_pkg::VALUE_FRAC_BITS_DEF,
    localparam int NW = COORD_WIDTH + FRAC_BITS + 2,
    localparam int DW = COORD_WIDTH + 1,
    localparam int TW = FRAC_BITS + 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic [NW-1:0]        num,
    input  logic [DW-1:0]        den,
    input  logic                 neg,
    input  logic                 tag_in,
    output logic signed [TW-1:0] t_out,
    output logic                 tag_out
);
    localparam int QB  = FRAC_BITS + 3;
    localparam int CPW = COORD_WIDTH + FRAC_BITS + 4;
    localparam logic [QB-1:0] LIM = QB'(1) << (FRAC_BITS + 2);

    logic [NW-1:0] rem_reg [0:QB];
    logic [DW-1:0] den_reg [0:QB];
    logic [QB-1:0] q_reg   [0:QB];
    logic          neg_reg [0:QB];
    logic          ovf_reg [0:QB];
    logic          tag_reg [0:QB];
    logic signed [TW-1:0] t_reg;
    logic                 tag_out_reg;
    logic [QB-1:0]        mag;
    logic signed [TW-1:0] mag_s;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            neg_reg[0] <= neg;
            ovf_reg[0] <= (CPW'(den) << QB) <= CPW'(num);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            tag_reg[0] <= tag_in;
        end
    end

    for (genvar i = 1; i <= QB; i++)
    begin : g_stage
        localparam int B = QB - i;
        logic [CPW-1:0] trial;
        logic           ge;

        assign trial = CPW'(den_reg[i-1]) << B;
        assign ge    = CPW'(rem_reg[i-1]) >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= ge ? NW'(CPW'(rem_reg[i-1]) - trial) : rem_reg[i-1];
                q_reg[i]   <= q_reg[i-1] | (QB'(ge) << B);
                den_reg[i] <= den_reg[i-1];
                neg_reg[i] <= neg_reg[i-1];
                ovf_reg[i] <= ovf_reg[i-1];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    assign mag   = (ovf_reg[QB] || (q_reg[QB] > LIM)) ? LIM : q_reg[QB];
    assign mag_s = $signed(TW'(mag));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg <= neg_reg[QB] ? -mag_s : mag_s;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_out_reg <= 1'b0;
        end
        else if (en)
        begin
            tag_out_reg <= tag_reg[QB];
        end
    end

    assign t_out   = t_reg;
    assign tag_out = tag_out_reg;
endmodule

// ===== rtl/qbi_front.sv =====
// Front end: takes pixel transactions, forms dividends and divisors, and queues them.
`timescale 1ns / 1ps
module qbi_front #(
    parameter int COORD_WIDTH = qbi_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = qbi_pkg::VALUE_FRAC_BITS_DEF,
    localparam int NW   = COORD_WIDTH + FRAC_BITS + 2,
    localparam int DW   = COORD_WIDTH + 1,
    localparam int ENTW = 2 * (NW + DW + 1) + 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [COORD_WIDTH-1:0] pixel_x,
    input  logic [COORD_WIDTH-1:0] pixel_y,
    input  logic [COORD_WIDTH-1:0] left_x,
    input  logic [COORD_WIDTH-1:0] top_y,
    input  logic [COORD_WIDTH-1:0] right_x,
    input  logic [COORD_WIDTH-1:0] bottom_y,
    output logic                   q_valid,
    output logic [ENTW-1:0]        q_data,
    input  logic                   q_pop
);
    localparam int SCW = COORD_WIDTH + 1;

    logic signed [SCW-1:0]  dx, dy, w, h;
    logic [COORD_WIDTH-1:0] dx_mag, dy_mag, w_mag, h_mag;
    logic [NW-1:0]          nx, ny;
    logic [DW-1:0]          ddx, ddy;
    logic                   err, push;
    logic [ENTW-1:0]        entry;

    logic [ENTW-1:0] mem [0:1];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;

    assign dx = $signed(SCW'(pixel_x)) - $signed(SCW'(left_x));
    assign dy = $signed(SCW'(pixel_y)) - $signed(SCW'(top_y));
    assign w  = $signed(SCW'(right_x)) - $signed(SCW'(left_x));
    assign h  = $signed(SCW'(bottom_y)) - $signed(SCW'(top_y));

    assign dx_mag = dx[SCW-1] ? COORD_WIDTH'(-dx) : COORD_WIDTH'(dx);
    assign dy_mag = dy[SCW-1] ? COORD_WIDTH'(-dy) : COORD_WIDTH'(dy);
    assign w_mag  = w[SCW-1]  ? COORD_WIDTH'(-w)  : COORD_WIDTH'(w);
    assign h_mag  = h[SCW-1]  ? COORD_WIDTH'(-h)  : COORD_WIDTH'(h);

    // Rounded division: quotient of (2n + m) by 2m.
    assign nx  = (NW'(dx_mag) << (FRAC_BITS + 1)) + NW'(w_mag);
    assign ny  = (NW'(dy_mag) << (FRAC_BITS + 1)) + NW'(h_mag);
    assign ddx = {w_mag, 1'b0};
    assign ddy = {h_mag, 1'b0};
    assign err = (w == '0) || (h == '0);

    assign entry = {err, dy[SCW-1] ^ h[SCW-1], ddy, ny, dx[SCW-1] ^ w[SCW-1], ddx, nx};

    assign in_ready = count_reg != 2'd2;
    assign push     = in_valid && in_ready;
    assign q_valid  = count_reg != 2'd0;
    assign q_data   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end
endmodule

// ===== rtl/qbi_back.sv =====
// Back end: division, blend polynomial, edge and final interpolation, saturation.
`timescale 1ns / 1ps
`include "quad_bicubic_interpolator_defines.svh"
module qbi_back #(
    parameter int COORD_WIDTH = qbi_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = qbi_pkg::VALUE_FRAC_BITS_DEF,
    localparam int NW   = COORD_WIDTH + FRAC_BITS + 2,
    localparam int DW   = COORD_WIDTH + 1,
    localparam int ENTW = 2 * (NW + DW + 1) + 1
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   q_valid,
    input  logic [ENTW-1:0]                        q_data,
    output logic                                   q_pop,
    input  qbi_pkg::corners_t                      corners,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [qbi_pkg::VALUE_WIDTH-1:0] interp_value,
    output logic                                   saturated,
    output logic                                   divide_error
);
    localparam int F     = FRAC_BITS;
    localparam int G     = qbi_pkg::GUARD_BITS;
    localparam int VW    = qbi_pkg::VALUE_WIDTH;
    localparam int TW    = F + 4;
    localparam int T2W   = F + 6;
    localparam int T3W   = F + 8;
    localparam int GW    = F + 9;
    localparam int SW    = F + 12;
    localparam int DIFW  = VW + 1;
    localparam int PEW   = DIFW + GW;
    localparam int SE    = F - G;
    localparam int EW    = PEW - SE + 2;
    localparam int DFW   = EW + 1;
    localparam int PLW   = DFW + 17;
    localparam int PHW   = DFW + GW - 16;
    localparam int PMW   = DFW + GW;
    localparam int RW    = PMW - F + 2;
    localparam int RND_F = (1 << F) >> 1;
    localparam int RND_E = (1 << SE) >> 1;
    localparam int RND_G = (1 << G) >> 1;
    localparam int NS    = 8;
    localparam int XO    = 0;
    localparam int YO    = NW + DW + 1;

    logic en;
    logic signed [TW-1:0] tx, ty;
    logic div_vld, div_err;

    logic [NS-1:0] vld_reg, err_reg;

    logic signed [TW-1:0]  tx1_reg, ty1_reg, tx2_reg, ty2_reg;
    logic signed [T2W-1:0] t2x_reg, t2y_reg, t2x2_reg, t2y2_reg;
    logic signed [T3W-1:0] t3x_reg, t3y_reg;
    logic signed [GW-1:0]  gx_reg, gy_reg, gx_e1_reg, gx_e2_reg;
    logic signed [PEW-1:0] pl_reg, pr_reg;
    logic signed [EW-1:0]  lft_reg, rgt_reg, lft_m1_reg, lft_m2_reg;
    logic signed [PLW-1:0] plo_reg;
    logic signed [PHW-1:0] phi_reg;
    logic signed [PMW-1:0] prod_reg;
    logic signed [RW-1:0]  r_reg;

    logic signed [2*TW-1:0]     sqx, sqy;
    logic signed [T2W+TW-1:0]   cbx, cby;
    logic signed [SW-1:0]       sumx, sumy;
    logic signed [DFW-1:0]      diff;
    logic signed [RW-1:0]       rr;

    logic signed [VW-1:0] val_reg, val_next;
    logic                 sat_reg, sat_next;
    logic                 err_out_reg;
    logic                 vld_out_reg;

    logic out_err, out_sat, err_clean, sat_end;

    assign en    = !vld_out_reg || out_ready;
    assign q_pop = en && q_valid;

    qbi_div #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div_x (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .num     (q_data[XO +: NW]),
        .den     (q_data[XO+NW +: DW]),
        .neg     (q_data[XO+NW+DW]),
        .tag_in  (q_pop),
        .t_out   (tx),
        .tag_out (div_vld)
    );

    qbi_div #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div_y (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .num     (q_data[YO +: NW]),
        .den     (q_data[YO+NW +: DW]),
        .neg     (q_data[YO+NW+DW]),
        .tag_in  (q_data[ENTW-1]),
        .t_out   (ty),
        .tag_out (div_err)
    );

    assign sqx  = (2*TW)'(tx) * (2*TW)'(tx);
    assign sqy  = (2*TW)'(ty) * (2*TW)'(ty);
    assign cbx  = (T2W+TW)'(t2x_reg) * (T2W+TW)'(tx1_reg);
    assign cby  = (T2W+TW)'(t2y_reg) * (T2W+TW)'(ty1_reg);
    assign sumx = SW'(tx2_reg) + SW'(3) * SW'(t2x2_reg) - SW'(2) * SW'(t3x_reg) + SW'(1);
    assign sumy = SW'(ty2_reg) + SW'(3) * SW'(t2y2_reg) - SW'(2) * SW'(t3y_reg) + SW'(1);
    assign diff = DFW'(rgt_reg) - DFW'(lft_reg);
    assign rr   = (r_reg + RW'(RND_G)) >>> G;

    always_comb
    begin
        val_next = VW'(rr);
        sat_next = 1'b0;
        if (err_reg[NS-1])
        begin
            val_next = '0;
        end
        else if (rr > RW'(qbi_pkg::VAL_MAX))
        begin
            val_next = VW'(qbi_pkg::VAL_MAX);
            sat_next = 1'b1;
        end
        else if (rr < RW'(qbi_pkg::VAL_MIN))
        begin
            val_next = VW'(qbi_pkg::VAL_MIN);
            sat_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tx1_reg    <= tx;
            ty1_reg    <= ty;
            t2x_reg    <= T2W'((sqx + (2*TW)'(RND_F)) >>> F);
            t2y_reg    <= T2W'((sqy + (2*TW)'(RND_F)) >>> F);
            tx2_reg    <= tx1_reg;
            ty2_reg    <= ty1_reg;
            t2x2_reg   <= t2x_reg;
            t2y2_reg   <= t2y_reg;
            t3x_reg    <= T3W'((cbx + (T2W+TW)'(RND_F)) >>> F);
            t3y_reg    <= T3W'((cby + (T2W+TW)'(RND_F)) >>> F);
            gx_reg     <= GW'(sumx >>> 1);
            gy_reg     <= GW'(sumy >>> 1);
            pl_reg     <= (PEW'(DIFW'(corners.bl) - DIFW'(corners.tl))) * PEW'(gy_reg);
            pr_reg     <= (PEW'(DIFW'(corners.br) - DIFW'(corners.tr))) * PEW'(gy_reg);
            gx_e1_reg  <= gx_reg;
            lft_reg    <= (EW'(corners.tl) <<< G) + EW'((pl_reg + PEW'(RND_E)) >>> SE);
            rgt_reg    <= (EW'(corners.tr) <<< G) + EW'((pr_reg + PEW'(RND_E)) >>> SE);
            gx_e2_reg  <= gx_e1_reg;
            plo_reg    <= PLW'(diff) * PLW'($signed({1'b0, gx_e2_reg[15:0]}));
            phi_reg    <= PHW'(diff) * PHW'(gx_e2_reg >>> 16);
            lft_m1_reg <= lft_reg;
            prod_reg   <= (PMW'(phi_reg) <<< 16) + PMW'(plo_reg);
            lft_m2_reg <= lft_m1_reg;
            r_reg      <= RW'(lft_m2_reg) + RW'((prod_reg + PMW'(RND_F)) >>> F);
            val_reg    <= val_next;
            sat_reg    <= sat_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            err_reg     <= '0;
            vld_out_reg <= 1'b0;
            err_out_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= {vld_reg[NS-2:0], div_vld};
            err_reg     <= {err_reg[NS-2:0], div_err};
            vld_out_reg <= vld_reg[NS-1];
            err_out_reg <= err_reg[NS-1];
        end
    end

    assign out_valid    = vld_out_reg;
    assign interp_value = val_reg;
    assign saturated    = sat_reg;
    assign divide_error = err_out_reg;

    assign out_err   = vld_out_reg && err_out_reg;
    assign out_sat   = vld_out_reg && sat_reg;
    assign err_clean = (val_reg == '0) && !sat_reg;
    assign sat_end   = (val_reg == VW'(qbi_pkg::VAL_MAX)) || (val_reg == VW'(qbi_pkg::VAL_MIN));

    `QBI_ASSERT(a_err_zero, clk, rst_n, out_err |-> err_clean, "error result not zero")
    `QBI_ASSERT(a_sat_ends, clk, rst_n, out_sat |-> sat_end, "saturated value not at range end")
    `QBI_ASSERT(a_pop_valid, clk, rst_n, q_pop |-> q_valid, "queue popped while empty")
    `QBI_ASSERT_NEXT(a_last_stage, clk, rst_n, vld_reg[NS-1] && en, vld_out_reg, "transaction lost")
endmodule

// ===== test/tb.sv =====
// Self-checking testbench of the quad bicubic interpolator.
`timescale 1ns / 1ps
module tb;
    localparam int CW = 12;
    localparam int FB = 14;
    localparam int LATENCY = FB + 15;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam longint T_MAX = longint'(4) << FB;

    typedef struct packed {
        logic [15:0] value;
        logic        sat;
        logic        div_err;
    } pixel_result_t;

    typedef struct {
        logic [CW-1:0] px;
        logic [CW-1:0] py;
        bit            known;
        pixel_result_t res;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic cfg_we;
    logic [qbi_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [qbi_pkg::CFG_DATA_W-1:0] cfg_wdata;

    logic [CW-1:0] quad_left, quad_top, quad_right, quad_bottom;
    logic signed [15:0] corner_tl, corner_tr, corner_br, corner_bl;

    pixel_result_t pending_pixels[$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit recv_hold = 0;
    int quiet_cycles = 0;

    quad_bicubic_interpolator dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    function automatic longint rnd_shift(longint v, int s);
        if (s == 0)
            return v;
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint norm_coord(longint d, longint span);
        longint n, m, q;
        n = (d < 0 ? -d : d) << FB;
        m = span < 0 ? -span : span;
        q = (2 * n + m) / (2 * m);
        if ((d < 0) != (span < 0))
            q = -q;
        if (q > T_MAX)
            q = T_MAX;
        if (q < -T_MAX)
            q = -T_MAX;
        return q;
    endfunction

    function automatic longint blend_weight(longint t);
        longint t2, t3;
        t2 = rnd_shift(t * t, FB);
        t3 = rnd_shift(t2 * t, FB);
        return rnd_shift(t + 3 * t2 - 2 * t3, 1);
    endfunction

    function automatic longint edge_value(longint c, longint d, longint g);
        return c * (longint'(1) << qbi_pkg::GUARD_BITS)
             + rnd_shift((d - c) * g, FB - qbi_pkg::GUARD_BITS);
    endfunction

    function automatic pixel_result_t interpolate_pixel(logic [CW-1:0] px, logic [CW-1:0] py);
        pixel_result_t res;
        longint w, h, gx, gy, lft, rgt, r;
        w = longint'(quad_right) - longint'(quad_left);
        h = longint'(quad_bottom) - longint'(quad_top);
        res = '{16'd0, 1'b0, 1'b0};
        if (w == 0 || h == 0)
        begin
            res.div_err = 1'b1;
            return res;
        end
        gx = blend_weight(norm_coord(longint'(px) - longint'(quad_left), w));
        gy = blend_weight(norm_coord(longint'(py) - longint'(quad_top), h));
        lft = edge_value(corner_tl, corner_bl, gy);
        rgt = edge_value(corner_tr, corner_br, gy);
        r = rnd_shift(lft + rnd_shift((rgt - lft) * gx, FB), qbi_pkg::GUARD_BITS);
        if (r > qbi_pkg::VAL_MAX)
        begin
            r = qbi_pkg::VAL_MAX;
            res.sat = 1'b1;
        end
        else if (r < qbi_pkg::VAL_MIN)
        begin
            r = qbi_pkg::VAL_MIN;
            res.sat = 1'b1;
        end
        res.value = r[15:0];
        return res;
    endfunction

    task automatic write_reg(qbi_pkg::cfg_reg_t idx, logic [15:0] data);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            qbi_pkg::REG_LEFT_X:   quad_left = data[CW-1:0];
            qbi_pkg::REG_TOP_Y:    quad_top = data[CW-1:0];
            qbi_pkg::REG_RIGHT_X:  quad_right = data[CW-1:0];
            qbi_pkg::REG_BOTTOM_Y: quad_bottom = data[CW-1:0];
            qbi_pkg::REG_VAL_TL:   corner_tl = data;
            qbi_pkg::REG_VAL_TR:   corner_tr = data;
            qbi_pkg::REG_VAL_BR:   corner_br = data;
            default:               corner_bl = data;
        endcase
        @(posedge clk);
    endtask

    task automatic set_quad(int l, int t, int r, int b, int vtl, int vtr, int vbr, int vbl);
        write_reg(qbi_pkg::REG_LEFT_X, 16'(l));
        write_reg(qbi_pkg::REG_TOP_Y, 16'(t));
        write_reg(qbi_pkg::REG_RIGHT_X, 16'(r));
        write_reg(qbi_pkg::REG_BOTTOM_Y, 16'(b));
        write_reg(qbi_pkg::REG_VAL_TL, 16'(vtl));
        write_reg(qbi_pkg::REG_VAL_TR, 16'(vtr));
        write_reg(qbi_pkg::REG_VAL_BR, 16'(vbr));
        write_reg(qbi_pkg::REG_VAL_BL, 16'(vbl));
    endtask

    task automatic send_pixel(logic [CW-1:0] px, logic [CW-1:0] py, bit known,
                              pixel_result_t res);
        pixel_result_t predicted;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {py, px};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = interpolate_pixel(px, py);
        if (known && predicted != res)
        begin
            $display("%0t table row disagrees with predictor: expected %h/%b/%b got %h/%b/%b",
                $time, res.value, res.sat, res.div_err,
                predicted.value, predicted.sat, predicted.div_err);
            errors++;
        end
        pending_pixels.push_back(known ? res : predicted);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic logic [CW-1:0] rand_near(int lo, int hi);
        int span, v;
        span = (hi > lo ? hi - lo : lo - hi) + 1;
        v = (lo < hi ? lo : hi) - span + $urandom_range(3 * span);
        if ($urandom_range(9) == 0)
            v = $urandom_range(4095);
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return CW'(v);
    endfunction

    task automatic random_phase(int count, int idle, int stall, bit holdoff);
        int l, t, r, b;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        l = $urandom_range(4095);
        t = $urandom_range(4095);
        r = ($urandom_range(3) == 0) ? $urandom_range(4095) : l + $urandom_range(64) - 16;
        b = ($urandom_range(3) == 0) ? $urandom_range(4095) : t + $urandom_range(64) - 16;
        if (r < 0) r = 0;
        if (r > 4095) r = 4095;
        if (b < 0) b = 0;
        if (b > 4095) b = 4095;
        if ($urandom_range(7) == 0)
            r = l;
        set_quad(l, t, r, b, $urandom, $urandom, $urandom, $urandom);
        if (holdoff)
            fork
            begin
                recv_hold = 1;
                repeat (300) @(posedge clk);
                recv_hold = 0;
            end
            join_none
        for (int i = 0; i < count; i++)
            send_pixel(rand_near(l, r), rand_near(t, b), 0, '{16'd0, 1'b0, 1'b0});
        drain();
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= !recv_hold && !(recv_stall_pct > 0 &&
                             $urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        pixel_result_t exp_res;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_pixels.size() == 0)
            begin
                $display("%0t unexpected result %h/%b", $time, m_axis_tdata, m_axis_tuser);
                errors++;
            end
            else
            begin
                exp_res = pending_pixels.pop_front();
                if (m_axis_tdata !== exp_res.value || m_axis_tuser[0] !== exp_res.sat ||
                    m_axis_tuser[1] !== exp_res.div_err)
                begin
                    $display("%0t mismatch: expected %h sat %b err %b, got %h sat %b err %b",
                        $time, exp_res.value, exp_res.sat, exp_res.div_err,
                        m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1]);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (!s_axis_tvalid && pending_pixels.size() == 0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    stim_row_t directed[$];

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        quad_left = 0;
        quad_top = 0;
        quad_right = 1;
        quad_bottom = 1;
        corner_tl = 0;
        corner_tr = 0;
        corner_br = 0;
        corner_bl = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset quad: all corners zero, so every pixel gives zero.
        directed = '{
            '{12'd0, 12'd0, 1, '{16'h0000, 1'b0, 1'b0}},
            '{12'd4095, 12'd4095, 1, '{16'h0000, 1'b0, 1'b0}},
            '{12'd1, 12'd0, 1, '{16'h0000, 1'b0, 1'b0}}
        };
        foreach (directed[i])
            send_pixel(directed[i].px, directed[i].py, directed[i].known, directed[i].res);
        drain();

        // Corners are met exactly; outside pixels extrapolate with clamping.
        set_quad(100, 200, 164, 232, 16'h4000, 16'hC000, 16'h7FFF, 16'h8000);
        directed = '{
            '{12'd100, 12'd200, 1, '{16'h4000, 1'b0, 1'b0}},
            '{12'd164, 12'd200, 1, '{16'hC000, 1'b0, 1'b0}},
            '{12'd164, 12'd232, 1, '{16'h7FFF, 1'b0, 1'b0}},
            '{12'd100, 12'd232, 1, '{16'h8000, 1'b0, 1'b0}},
            '{12'd132, 12'd216, 0, '{16'h0, 1'b0, 1'b0}},
            '{12'd0, 12'd0, 0, '{16'h0, 1'b0, 1'b0}},
            '{12'd4095, 12'd4095, 0, '{16'h0, 1'b0, 1'b0}},
            '{12'd4095, 12'd0, 0, '{16'h0, 1'b0, 1'b0}},
            '{12'd170, 12'd240, 0, '{16'h0, 1'b0, 1'b0}},
            '{12'd90, 12'd190, 0, '{16'h0, 1'b0, 1'b0}}
        };
        foreach (directed[i])
            send_pixel(directed[i].px, directed[i].py, directed[i].known, directed[i].res);
        drain();

        // Reversed corners, then a zero-width quad and a zero-height quad.
        set_quad(4095, 4095, 0, 0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        directed = '{
            '{12'd4095, 12'd4095, 1, '{16'h7FFF, 1'b0, 1'b0}},
            '{12'd0, 12'd0, 0, '{16'h0, 1'b0, 1'b0}},
            '{12'd2048, 12'd1000, 0, '{16'h0, 1'b0, 1'b0}}
        };
        foreach (directed[i])
            send_pixel(directed[i].px, directed[i].py, directed[i].known, directed[i].res);
        drain();
        write_reg(qbi_pkg::REG_RIGHT_X, 16'd4095);
        directed = '{
            '{12'd5, 12'd5, 1, '{16'h0000, 1'b0, 1'b1}},
            '{12'd4095, 12'd0, 1, '{16'h0000, 1'b0, 1'b1}}
        };
        foreach (directed[i])
            send_pixel(directed[i].px, directed[i].py, directed[i].known, directed[i].res);
        drain();
        write_reg(qbi_pkg::REG_RIGHT_X, 16'd0);
        write_reg(qbi_pkg::REG_BOTTOM_Y, 16'd4095);
        send_pixel(12'd7, 12'd9, 1, '{16'h0000, 1'b0, 1'b1});
        drain();

        for (int p = 0; p < 16; p++)
            random_phase(60, (p % 4 == 1) ? 85 : (p % 4 == 3 ? 14 : 0),
                (p % 4 == 2) ? 85 : (p % 4 == 3 ? 14 : 0), p == 4);
        send_idle_pct = 14;
        random_phase(40, 14, 14, 0);

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
